// ----- sv/lsre_pkg.sv -----
// Shared types and constants of the link-state route engine.
package lsre_pkg;

   localparam int NODE_BITS  = 4;
   localparam int PAIR_BITS  = 2 * NODE_BITS;
   localparam int COST_BITS  = 16;
   localparam int RCOST_BITS = 21;
   localparam int PCOST_BITS = 20;

   localparam logic [RCOST_BITS-1:0] INF_COST = 21'h100000;
   localparam logic [PCOST_BITS-1:0] SAT_COST = 20'hFFFFF;
   localparam logic [NODE_BITS-1:0]  LAST_NODE = 4'd15;
   localparam logic [NODE_BITS-1:0]  TRACE_LAST = 4'd15;

   typedef enum logic [1:0] {
      REQ_WRITE    = 2'd0,
      REQ_CONVERGE = 2'd1,
      REQ_READ     = 2'd2,
      REQ_TRACE    = 2'd3
   } req_kind_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_WRITE, OP_WRITE2, OP_INIT_RD, OP_INIT_WR,
      OP_SRC_START, OP_NEXT_SRC, OP_SEL_START, OP_SEL_RD, OP_SEL_CMP, OP_SEL_END,
      OP_BASE_RD, OP_BASE_CHK, OP_RLX_RD, OP_RLX_CMP, OP_CHS_INIT, OP_CH_RD,
      OP_CH_CHK, OP_CHW_INIT, OP_RLX_WR, OP_RLX_NEXT, OP_LOOK_RD, OP_LOOK,
      OP_EMIT, OP_TR_RD, OP_TR_CAP
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_WRITE, S_WRITE2, S_INIT_RD, S_INIT_WR, S_SRC, S_NEXT_SRC, S_LOOP,
      S_SEL_RD, S_SEL_CMP, S_SEL_END, S_BASE_RD, S_BASE_CHK, S_RLX_RD, S_RLX_CMP,
      S_CHS_INIT, S_CHS_RD, S_CHS_CHK, S_CHW_INIT, S_CHW_RD, S_CHW_CHK, S_CH_CMP,
      S_RLX_WR, S_RLX_NEXT, S_LOOK_RD, S_LOOK, S_RSP, S_EMIT, S_TR_WAIT, S_TR_RD,
      S_TR_CAP
   } ctrl_state_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic init_last;
      logic s_present;
      logic s_last;
      logic done_full;
      logic d_last;
      logic found;
      logic base_inf;
      logic v_last;
      logic elig;
      logic lt;
      logic eq;
      logic ch_end;
      logic es_gt;
      logic look_trace;
      logic rsp_fire;
      logic out_last;
   } dp_status_type;

endpackage

// ----- sv/link_state_route_engine_top.sv -----
// Top level of the link-state route engine: controller plus datapath.
//
// The engine keeps a symmetric table of link costs over sixteen nodes and a
// routing table computed from it with Dijkstra's algorithm from every present node.
// Requests arrive on the req_ stream, one transfer per request; req_tuser
// says what the request is (write link, converge, read route, trace path).
// Results leave on the rsp_ stream; rsp_tlast marks the final result transfer
// of a request. Link writes and converges produce no result; a route read
// produces one; a trace produces the source and each intermediate hop, up to
// sixteen transfers, or a single unreachable result.
// The engine works on one request at a time. A converge first rebuilds the
// route table from the link table, then per present source makes up to 15
// selections, each of a node at finite cost followed by 16 relaxation steps;
// the two next-hop chain walks on an equal-cost tie, one memory read per step,
// dominate the worst case.
// Reset is synchronous; it clears the link states, the present set and the
// output valid; routes read as unreachable until the first converge.
// When the receiver stalls, the result is held in the output register and
// the engine waits; no request is taken until the last result has gone.
module link_state_route_engine_top
   import lsre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // node_a [3:0], node_b [7:4], link_cost [23:8], link_broken [24], zero fill.
   input  logic [31:0] req_tdata,
   // req_type [1:0].
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // reachable [0], path_cost [20:1], first_hop [24:21], hop_node [28:25], zero fill.
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   dp_cmd_type    cmd;
   dp_status_type sts;

   // The controller sequences every request; the datapath only acts on its commands.
   lsre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   lsre_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- sv/lsre_ctrl.sv -----
// Control state machine of the link-state route engine.
module lsre_ctrl
   import lsre_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic [1:0]    req_tuser,
   output logic          req_tready,
   output dp_cmd_type    cmd,
   input  dp_status_type sts
);

   ctrl_state_type state_ff, state_in;
   req_kind_type   kind;

   assign kind = req_kind_type'(req_tuser);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = OP_ACCEPT;
               case (kind)
                  REQ_WRITE:    state_in = S_WRITE;
                  REQ_CONVERGE: state_in = S_INIT_RD;
                  default:      state_in = S_LOOK_RD;
               endcase
            end
         end
         S_WRITE: begin
            cmd.op   = OP_WRITE;
            state_in = S_WRITE2;
         end
         S_WRITE2: begin
            cmd.op   = OP_WRITE2;
            state_in = S_IDLE;
         end
         S_INIT_RD: begin
            cmd.op   = OP_INIT_RD;
            state_in = S_INIT_WR;
         end
         S_INIT_WR: begin
            cmd.op   = OP_INIT_WR;
            state_in = sts.init_last ? S_SRC : S_INIT_RD;
         end
         S_SRC: begin
            cmd.op   = OP_SRC_START;
            state_in = sts.s_present ? S_LOOP : S_NEXT_SRC;
         end
         S_NEXT_SRC: begin
            cmd.op   = OP_NEXT_SRC;
            state_in = sts.s_last ? S_IDLE : S_SRC;
         end
         S_LOOP: begin
            cmd.op   = OP_SEL_START;
            state_in = sts.done_full ? S_NEXT_SRC : S_SEL_RD;
         end
         S_SEL_RD: begin
            cmd.op   = OP_SEL_RD;
            state_in = S_SEL_CMP;
         end
         S_SEL_CMP: begin
            cmd.op   = OP_SEL_CMP;
            state_in = sts.d_last ? S_SEL_END : S_SEL_RD;
         end
         S_SEL_END: begin
            cmd.op   = OP_SEL_END;
            state_in = sts.found ? S_BASE_RD : S_NEXT_SRC;
         end
         S_BASE_RD: begin
            cmd.op   = OP_BASE_RD;
            state_in = S_BASE_CHK;
         end
         S_BASE_CHK: begin
            cmd.op   = OP_BASE_CHK;
            state_in = sts.base_inf ? S_LOOP : S_RLX_RD;
         end
         S_RLX_RD: begin
            cmd.op   = OP_RLX_RD;
            state_in = S_RLX_CMP;
         end
         S_RLX_CMP: begin
            cmd.op = OP_RLX_CMP;
            if (!sts.elig) begin
               state_in = S_RLX_NEXT;
            end else if (sts.lt) begin
               state_in = S_RLX_WR;
            end else if (sts.eq) begin
               state_in = S_CHS_INIT;
            end else begin
               state_in = S_RLX_NEXT;
            end
         end
         S_CHS_INIT: begin
            cmd.op   = OP_CHS_INIT;
            state_in = S_CHS_RD;
         end
         S_CHS_RD: begin
            cmd.op   = OP_CH_RD;
            state_in = S_CHS_CHK;
         end
         S_CHS_CHK: begin
            cmd.op   = OP_CH_CHK;
            state_in = sts.ch_end ? S_CHW_INIT : S_CHS_RD;
         end
         S_CHW_INIT: begin
            cmd.op   = OP_CHW_INIT;
            state_in = S_CHW_RD;
         end
         S_CHW_RD: begin
            cmd.op   = OP_CH_RD;
            state_in = S_CHW_CHK;
         end
         S_CHW_CHK: begin
            cmd.op   = OP_CH_CHK;
            state_in = sts.ch_end ? S_CH_CMP : S_CHW_RD;
         end
         S_CH_CMP: begin
            state_in = sts.es_gt ? S_RLX_WR : S_RLX_NEXT;
         end
         S_RLX_WR: begin
            cmd.op   = OP_RLX_WR;
            state_in = S_RLX_NEXT;
         end
         S_RLX_NEXT: begin
            cmd.op   = OP_RLX_NEXT;
            state_in = sts.v_last ? S_LOOP : S_RLX_RD;
         end
         S_LOOK_RD: begin
            cmd.op   = OP_LOOK_RD;
            state_in = S_LOOK;
         end
         S_LOOK: begin
            cmd.op   = OP_LOOK;
            state_in = sts.look_trace ? S_EMIT : S_RSP;
         end
         S_RSP: begin
            if (sts.rsp_fire) begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            cmd.op   = OP_EMIT;
            state_in = S_TR_WAIT;
         end
         S_TR_WAIT: begin
            if (sts.rsp_fire) begin
               state_in = sts.out_last ? S_IDLE : S_TR_RD;
            end
         end
         S_TR_RD: begin
            cmd.op   = OP_TR_RD;
            state_in = S_TR_CAP;
         end
         S_TR_CAP: begin
            cmd.op   = OP_TR_CAP;
            state_in = S_EMIT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/lsre_dpath.sv -----
// Datapath of the link-state route engine: link and route memories, counters, output register.
module lsre_dpath
   import lsre_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [31:0]   req_tdata,
   input  logic [1:0]    req_tuser,
   input  dp_cmd_type    cmd,
   output dp_status_type sts,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,
   output logic          rsp_tlast
);

   // Memories.
   logic [COST_BITS-1:0]  weight_mem [2**PAIR_BITS];
   logic [RCOST_BITS-1:0] cost_mem   [2**PAIR_BITS];
   logic [NODE_BITS-1:0]  hop_mem    [2**PAIR_BITS];
   logic [2**PAIR_BITS-1:0] link_up_ff;

   logic [COST_BITS-1:0]  wgt_rd_ff;
   logic [RCOST_BITS-1:0] cost_rd_ff;
   logic [NODE_BITS-1:0]  hop_rd_ff;

   // Request fields.
   logic [NODE_BITS-1:0] a_ff, b_ff;
   logic [COST_BITS-1:0] lcost_ff;
   logic                 broken_ff;
   logic                 trace_ff;

   // Converge state.
   logic [2**NODE_BITS-1:0] present_ff, done_ff;
   logic                    conv_ff;
   logic [PAIR_BITS-1:0]    i_ff;
   logic [NODE_BITS-1:0]    s_ff, d_ff, w_ff, v_ff, x_ff, es_ff, step_ff, hsw_ff;
   logic [RCOST_BITS-1:0]   best_ff;
   logic                    found_ff;
   logic [PCOST_BITS-1:0]   sum_ff;

   // Trace state.
   logic [PCOST_BITS-1:0] pc_ff;
   logic [NODE_BITS-1:0]  first_ff, nx_ff, cnt_ff;

   // Output register.
   logic                  rsp_valid_ff;
   logic                  o_reach_ff, o_last_ff;
   logic [PCOST_BITS-1:0] o_cost_ff;
   logic [NODE_BITS-1:0]  o_next_ff, o_hop_ff;

   logic                  rsp_fire;
   logic [PAIR_BITS-1:0]  wgt_wa, wgt_ra, cost_ra, hop_ra, rt_wa;
   logic                  wgt_we, rt_we;
   logic [COST_BITS-1:0]  wgt_wd;
   logic [RCOST_BITS-1:0] cost_wd, init_cost;
   logic [NODE_BITS-1:0]  hop_wd, init_s, init_d, ch_h;
   logic [RCOST_BITS-1:0] raw_sum;
   logic [PCOST_BITS-1:0] sum_sat;
   logic                  sel_cand, look_ok;

   assign rsp_fire = rsp_valid_ff & rsp_tready;
   assign init_s   = i_ff[PAIR_BITS-1:NODE_BITS];
   assign init_d   = i_ff[NODE_BITS-1:0];
   assign ch_h     = hop_rd_ff;

   always_comb begin
      if (!(present_ff[init_s] && present_ff[init_d])) begin
         init_cost = INF_COST;
      end else if (init_s == init_d) begin
         init_cost = '0;
      end else if (link_up_ff[i_ff]) begin
         init_cost = {{(RCOST_BITS-COST_BITS){1'b0}}, wgt_rd_ff};
      end else begin
         init_cost = INF_COST;
      end
   end

   assign raw_sum = best_ff + {{(RCOST_BITS-COST_BITS){1'b0}}, wgt_rd_ff};
   assign sum_sat = (raw_sum > {1'b0, SAT_COST}) ? SAT_COST : raw_sum[PCOST_BITS-1:0];
   assign sel_cand = present_ff[d_ff] && !done_ff[d_ff] && (!found_ff || cost_rd_ff < best_ff);
   assign look_ok  = conv_ff && present_ff[a_ff] && present_ff[b_ff] && !cost_rd_ff[RCOST_BITS-1];

   // Address and write selection.
   always_comb begin
      wgt_we  = (cmd.op == OP_WRITE || cmd.op == OP_WRITE2) && (a_ff != b_ff);
      wgt_wa  = (cmd.op == OP_WRITE2) ? {b_ff, a_ff} : {a_ff, b_ff};
      wgt_wd  = broken_ff ? '0 : lcost_ff;
      wgt_ra  = (cmd.op == OP_RLX_RD) ? {w_ff, v_ff} : i_ff;
      rt_we   = (cmd.op == OP_INIT_WR) || (cmd.op == OP_RLX_WR);
      rt_wa   = (cmd.op == OP_INIT_WR) ? i_ff : {s_ff, v_ff};
      cost_wd = (cmd.op == OP_INIT_WR) ? init_cost : {1'b0, sum_ff};
      hop_wd  = (cmd.op == OP_INIT_WR) ? init_d : hsw_ff;
      case (cmd.op)
         OP_SEL_RD:  cost_ra = {s_ff, d_ff};
         OP_RLX_RD:  cost_ra = {s_ff, v_ff};
         default:    cost_ra = {a_ff, b_ff};
      endcase
      case (cmd.op)
         OP_BASE_RD: hop_ra = {s_ff, w_ff};
         OP_CH_RD:   hop_ra = {x_ff, v_ff};
         OP_TR_RD:   hop_ra = {nx_ff, b_ff};
         default:    hop_ra = {a_ff, b_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         weight_mem[wgt_wa] <= wgt_wd;
      end
      wgt_rd_ff <= weight_mem[wgt_ra];
   end

   always_ff @(posedge clock) begin
      if (rt_we) begin
         cost_mem[rt_wa] <= cost_wd;
      end
      cost_rd_ff <= cost_mem[cost_ra];
   end

   always_ff @(posedge clock) begin
      if (rt_we) begin
         hop_mem[rt_wa] <= hop_wd;
      end
      hop_rd_ff <= hop_mem[hop_ra];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_up_ff   <= '0;
         present_ff   <= '0;
         done_ff      <= '0;
         conv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_WRITE: begin
               present_ff[a_ff] <= 1'b1;
               present_ff[b_ff] <= 1'b1;
               if (a_ff != b_ff) begin
                  link_up_ff[{a_ff, b_ff}] <= !broken_ff;
                  link_up_ff[{b_ff, a_ff}] <= !broken_ff;
               end
            end
            OP_INIT_RD:   conv_ff <= 1'b1;
            OP_SRC_START: begin
               if (present_ff[s_ff]) begin
                  done_ff <= '0;
                  done_ff[s_ff] <= 1'b1;
               end
            end
            OP_SEL_END: begin
               if (found_ff) begin
                  done_ff[w_ff] <= 1'b1;
               end
            end
            OP_LOOK: begin
               if (!look_ok || !trace_ff) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            OP_EMIT:      rsp_valid_ff <= 1'b1;
            default: begin
            end
         endcase
      end
   end

   // Payload and counters.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            a_ff      <= req_tdata[3:0];
            b_ff      <= req_tdata[7:4];
            lcost_ff  <= req_tdata[23:8];
            broken_ff <= req_tdata[24];
            trace_ff  <= (req_kind_type'(req_tuser) == REQ_TRACE);
            i_ff      <= '0;
            s_ff      <= '0;
         end
         OP_INIT_WR:  i_ff <= i_ff + 1'b1;
         OP_NEXT_SRC: s_ff <= s_ff + 1'b1;
         OP_SEL_START: begin
            d_ff     <= '0;
            found_ff <= 1'b0;
         end
         OP_SEL_CMP: begin
            if (sel_cand) begin
               found_ff <= 1'b1;
               best_ff  <= cost_rd_ff;
               w_ff     <= d_ff;
            end
            d_ff <= d_ff + 1'b1;
         end
         OP_BASE_CHK: begin
            hsw_ff <= hop_rd_ff;
            v_ff   <= '0;
         end
         OP_RLX_CMP:  sum_ff <= sum_sat;
         OP_CHS_INIT: begin
            x_ff    <= s_ff;
            step_ff <= '0;
         end
         OP_CH_CHK: begin
            if (ch_h != v_ff) begin
               x_ff <= ch_h;
            end
            step_ff <= step_ff + 1'b1;
         end
         OP_CHW_INIT: begin
            es_ff   <= x_ff;
            x_ff    <= w_ff;
            step_ff <= '0;
         end
         OP_RLX_NEXT: v_ff <= v_ff + 1'b1;
         OP_LOOK: begin
            if (!look_ok) begin
               o_reach_ff <= 1'b0;
               o_cost_ff  <= '0;
               o_next_ff  <= '0;
               o_hop_ff   <= trace_ff ? a_ff : '0;
               o_last_ff  <= 1'b1;
            end else if (!trace_ff) begin
               o_reach_ff <= 1'b1;
               o_cost_ff  <= cost_rd_ff[PCOST_BITS-1:0];
               o_next_ff  <= hop_rd_ff;
               o_hop_ff   <= '0;
               o_last_ff  <= 1'b1;
            end
            pc_ff    <= cost_rd_ff[PCOST_BITS-1:0];
            first_ff <= hop_rd_ff;
            nx_ff    <= hop_rd_ff;
            x_ff     <= a_ff;
            cnt_ff   <= '0;
         end
         OP_EMIT: begin
            o_reach_ff <= 1'b1;
            o_cost_ff  <= pc_ff;
            o_next_ff  <= first_ff;
            o_hop_ff   <= x_ff;
            o_last_ff  <= (nx_ff == b_ff) || (cnt_ff == TRACE_LAST);
         end
         OP_TR_RD: begin
            x_ff   <= nx_ff;
            cnt_ff <= cnt_ff + 1'b1;
         end
         OP_TR_CAP:   nx_ff <= hop_rd_ff;
         default: begin
         end
      endcase
   end

   // Status toward the controller.
   always_comb begin
      sts.init_last  = (i_ff == {PAIR_BITS{1'b1}});
      sts.s_present  = present_ff[s_ff];
      sts.s_last     = (s_ff == LAST_NODE);
      sts.done_full  = (done_ff == present_ff);
      sts.d_last     = (d_ff == LAST_NODE);
      sts.found      = found_ff;
      sts.base_inf   = best_ff[RCOST_BITS-1];
      sts.v_last     = (v_ff == LAST_NODE);
      sts.elig       = (v_ff != w_ff) && present_ff[v_ff] && !done_ff[v_ff]
                       && link_up_ff[{w_ff, v_ff}];
      sts.lt         = ({1'b0, sum_sat} < cost_rd_ff);
      sts.eq         = ({1'b0, sum_sat} == cost_rd_ff);
      sts.ch_end     = (ch_h == v_ff) || (step_ff == LAST_NODE);
      sts.es_gt      = (es_ff > x_ff);
      sts.look_trace = look_ok && trace_ff;
      sts.rsp_fire   = rsp_fire;
      sts.out_last   = o_last_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {3'b000, o_hop_ff, o_next_ff, o_cost_ff, o_reach_ff};

   a_done_in_present: assert property (@(posedge clock) disable iff (reset)
      (done_ff & ~present_ff) == '0)
      else $error("finished set holds a node that is not present");

   // The first half of a link write has already updated both directions.
   a_link_symmetric: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_WRITE2 |-> link_up_ff[{a_ff, b_ff}] == link_up_ff[{b_ff, a_ff}])
      else $error("link state is not symmetric");

   a_partial_reachable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !o_last_ff |-> o_reach_ff)
      else $error("non-final trace item marked unreachable");

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !o_reach_ff |-> (o_cost_ff == '0) && (o_next_ff == '0))
      else $error("unreachable result carries cost or hop");

endmodule
